// ----- hdl/iqtng_pkg.sv -----
`default_nettype none

package iqtng_pkg;

	localparam int PHASE_BITS_DEF      = 32;
	localparam int TABLE_ADDR_BITS_DEF = 10;
	localparam int SAMPLE_BITS_DEF     = 16;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 32;
	localparam int GAIN_BITS      = 16;
	localparam int NOISE_BITS     = 32;

	localparam logic [NOISE_BITS-1:0]    SEED_DEFAULT      = 32'd123456789;
	localparam logic [CFG_DATA_BITS-1:0] PHASE_STEP_RESET  = 32'd429497;
	localparam logic [GAIN_BITS-1:0]     TONE_GAIN_RESET   = 16'd32768;
	localparam logic [GAIN_BITS-1:0]     NOISE_GAIN_RESET  = 16'd3277;
	localparam logic [63:0]              HALF_PI_Q30       = 64'd1686629713;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_PHASE_STEP,
		REG_NOISE_SEED,
		REG_TONE_GAIN,
		REG_NOISE_GAIN
	} cfg_reg_t;

	typedef enum logic [1:0] {
		QUAD_0,
		QUAD_1,
		QUAD_2,
		QUAD_3
	} quad_t;

	typedef struct packed {
		logic s2;
		logic s3;
	} stage_en_t;

	function automatic logic [NOISE_BITS-1:0] xorshift_next(input logic [NOISE_BITS-1:0] s_in);
		logic [NOISE_BITS-1:0] s;
		s = s_in;
		s = s ^ (s << 13);
		s = s ^ (s >> 17);
		s = s ^ (s << 5);
		return s;
	endfunction

	// sin(pi/2 * k / 2^addr_bits) scaled by 2^(sample_bits-2), taylor series in q30
	function automatic logic [63:0] quarter_sin(input int unsigned k,
			input int unsigned addr_bits, input int unsigned sample_bits);
		logic [63:0] x;
		logic [63:0] sum;
		logic [63:0] term;
		logic [63:0] r;
		logic [63:0] one;
		int unsigned sh;
		int n;
		x = (64'(k) * HALF_PI_Q30) >> addr_bits;
		sum = x;
		term = x;
		for (n = 1; n <= 7; n++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			unique case (n)
				1: term = term / 6;
				2: term = term / 20;
				3: term = term / 42;
				4: term = term / 72;
				5: term = term / 110;
				6: term = term / 156;
				default: term = term / 210;
			endcase
			if (n % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		sh = 32 - sample_bits;
		r = (sum + (64'd1 << (sh - 1))) >> sh;
		one = 64'd1 << (sample_bits - 2);
		if (r > one) begin
			r = one;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/iqtng_sine_rom.sv -----
`default_nettype none

module iqtng_sine_rom #(
	parameter int TABLE_ADDR_BITS = iqtng_pkg::TABLE_ADDR_BITS_DEF,
	parameter int SAMPLE_BITS     = iqtng_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       rd_en,
	input  wire logic [TABLE_ADDR_BITS:0]   addr_a,
	input  wire logic [TABLE_ADDR_BITS:0]   addr_b,
	output logic      [SAMPLE_BITS-2:0]     data_a,
	output logic      [SAMPLE_BITS-2:0]     data_b
);

	localparam int DEPTH = 2**TABLE_ADDR_BITS + 1;

	logic [SAMPLE_BITS-2:0] rom_mem [DEPTH];

	for (genvar k = 0; k < DEPTH; k++) begin : g_entry
		localparam logic [63:0] ENTRY =
			iqtng_pkg::quarter_sin(k, TABLE_ADDR_BITS, SAMPLE_BITS);
		assign rom_mem[k] = ENTRY[SAMPLE_BITS-2:0];
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			data_a <= rom_mem[addr_a];
			data_b <= rom_mem[addr_b];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/iqtng_mix.sv -----
`default_nettype none

module iqtng_mix #(
	parameter int SAMPLE_BITS = iqtng_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire iqtng_pkg::stage_en_t                en,
	input  wire logic        [SAMPLE_BITS-2:0]       ta_s1,
	input  wire logic        [SAMPLE_BITS-2:0]       tb_s1,
	input  wire iqtng_pkg::quad_t                    quad_s1,
	input  wire logic        [iqtng_pkg::NOISE_BITS-1:0] wi_s1,
	input  wire logic        [iqtng_pkg::NOISE_BITS-1:0] wq_s1,
	input  wire logic                                last_s1,
	input  wire logic        [iqtng_pkg::GAIN_BITS-1:0]  tone_gain,
	input  wire logic        [iqtng_pkg::GAIN_BITS-1:0]  noise_gain,
	output logic signed      [SAMPLE_BITS-1:0]       i_s3,
	output logic signed      [SAMPLE_BITS-1:0]       q_s3,
	output logic                                     last_s3
);

	localparam int TP_BITS     = SAMPLE_BITS + 17;
	localparam int NP_BITS     = 49;
	localparam int NOISE_SHIFT = 48 - SAMPLE_BITS;
	localparam int SUM_BITS    = SAMPLE_BITS + 3;

	localparam logic signed [TP_BITS-1:0]  TONE_RND  = TP_BITS'(16384);
	localparam logic signed [NP_BITS-1:0]  NOISE_RND = NP_BITS'(1) <<< (NOISE_SHIFT - 1);
	localparam logic signed [SUM_BITS-1:0] SAT_HI    = SUM_BITS'(2**(SAMPLE_BITS-1) - 1);
	localparam logic signed [SUM_BITS-1:0] SAT_LO    = SUM_BITS'(-(2**(SAMPLE_BITS-1)));

	logic signed [SAMPLE_BITS-1:0] ta_sx, tb_sx, cos_v, sin_v;
	logic signed [16:0]            tone_g, noise_g;
	logic signed [TP_BITS-1:0]     tone_i_s2, tone_q_s2;
	logic signed [NP_BITS-1:0]     noise_i_s2, noise_q_s2;
	logic                          last_s2;
	logic signed [TP_BITS-1:0]     tone_i_r, tone_q_r;
	logic signed [NP_BITS-1:0]     noise_i_r, noise_q_r;
	logic signed [SUM_BITS-1:0]    sum_i, sum_q;

	function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [SUM_BITS-1:0] v);
		if (v > SAT_HI) begin
			return SAT_HI[SAMPLE_BITS-1:0];
		end else if (v < SAT_LO) begin
			return SAT_LO[SAMPLE_BITS-1:0];
		end
		return v[SAMPLE_BITS-1:0];
	endfunction

	assign ta_sx   = signed'({1'b0, ta_s1});
	assign tb_sx   = signed'({1'b0, tb_s1});
	assign tone_g  = signed'({1'b0, tone_gain});
	assign noise_g = signed'({1'b0, noise_gain});

	always_comb begin
		unique case (quad_s1)
			iqtng_pkg::QUAD_0: begin sin_v = ta_sx;  cos_v = tb_sx;  end
			iqtng_pkg::QUAD_1: begin sin_v = tb_sx;  cos_v = -ta_sx; end
			iqtng_pkg::QUAD_2: begin sin_v = -ta_sx; cos_v = -tb_sx; end
			iqtng_pkg::QUAD_3: begin sin_v = -tb_sx; cos_v = ta_sx;  end
		endcase
	end

	// products
	always_ff @(posedge clk) begin
		if (en.s2) begin
			tone_i_s2  <= TP_BITS'(cos_v) * TP_BITS'(tone_g);
			tone_q_s2  <= TP_BITS'(sin_v) * TP_BITS'(tone_g);
			noise_i_s2 <= NP_BITS'(signed'(wi_s1)) * NP_BITS'(noise_g);
			noise_q_s2 <= NP_BITS'(signed'(wq_s1)) * NP_BITS'(noise_g);
			last_s2    <= last_s1;
		end
	end

	// round half up, floor shift, add, saturate
	assign tone_i_r  = tone_i_s2 + TONE_RND;
	assign tone_q_r  = tone_q_s2 + TONE_RND;
	assign noise_i_r = noise_i_s2 + NOISE_RND;
	assign noise_q_r = noise_q_s2 + NOISE_RND;

	assign sum_i = SUM_BITS'(signed'(tone_i_r[TP_BITS-1:15]))
		+ SUM_BITS'(signed'(noise_i_r[NP_BITS-1:NOISE_SHIFT]));
	assign sum_q = SUM_BITS'(signed'(tone_q_r[TP_BITS-1:15]))
		+ SUM_BITS'(signed'(noise_q_r[NP_BITS-1:NOISE_SHIFT]));

	always_ff @(posedge clk) begin
		if (en.s3) begin
			i_s3    <= sat(sum_i);
			q_s3    <= sat(sum_q);
			last_s3 <= last_s2;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/iq_tone_plus_noise_generator.sv -----
// channel   direction  handshake               payload
// sample    in         sample_valid/sample_stall  block_end
// iq        out        iq_valid/iq_stall       i_sample, q_sample, last
// cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// one sample per clock sustained unless iq stalls; iq_valid is stage 3's valid flag
// stage 1 is the registered read of the quarter-wave table, stage 2 the gain
// multipliers, stage 3 rounding, noise add and saturation into the output register
// reset clears phase to zero and loads the noise state with 123456789
// a stall on iq holds the output; empty stages still fill, so sample_stall
// rises only when all three stages are full

`default_nettype none

module iq_tone_plus_noise_generator #(
	parameter int PHASE_BITS      = iqtng_pkg::PHASE_BITS_DEF,
	parameter int TABLE_ADDR_BITS = iqtng_pkg::TABLE_ADDR_BITS_DEF,
	parameter int SAMPLE_BITS     = iqtng_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      sample_valid,
	output logic                                           sample_stall,
	input  wire logic                                      block_end,
	output logic                                           iq_valid,
	input  wire logic                                      iq_stall,
	output logic signed [SAMPLE_BITS-1:0]                  i_sample,
	output logic signed [SAMPLE_BITS-1:0]                  q_sample,
	output logic                                           last,
	input  wire logic                                      cfg_valid,
	output logic                                           cfg_ready,
	input  wire logic   [iqtng_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  wire logic   [iqtng_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

	localparam logic [TABLE_ADDR_BITS:0] QTR_N = (TABLE_ADDR_BITS+1)'(1) << TABLE_ADDR_BITS;

	logic [iqtng_pkg::CFG_DATA_BITS-1:0] phase_step_q;
	logic [iqtng_pkg::GAIN_BITS-1:0]     tone_gain_q;
	logic [iqtng_pkg::GAIN_BITS-1:0]     noise_gain_q;
	logic [PHASE_BITS-1:0]               phase_acc_q;
	logic [iqtng_pkg::NOISE_BITS-1:0]    noise_q;

	logic [iqtng_pkg::NOISE_BITS-1:0]    wi, wq;
	logic [iqtng_pkg::NOISE_BITS-1:0]    wi_s1, wq_s1;
	iqtng_pkg::quad_t                    quad_s1;
	logic                                last_s1;
	logic [SAMPLE_BITS-2:0]              ta_s1, tb_s1;
	logic [TABLE_ADDR_BITS:0]            addr_a, addr_b;

	logic                                v_s1, v_s2, v_s3;
	logic                                ld1, ld2, ld3;
	logic                                take_in;
	logic                                cfg_we;
	iqtng_pkg::stage_en_t                en;

	assign ld3 = !v_s3 || !iq_stall;
	assign ld2 = !v_s2 || ld3;
	assign ld1 = !v_s1 || ld2;

	assign sample_stall = !ld1;
	assign take_in      = sample_valid && ld1;
	assign cfg_ready    = 1'b1;
	assign cfg_we       = cfg_valid && cfg_ready;
	assign iq_valid     = v_s3;

	assign en.s2 = ld2;
	assign en.s3 = ld3;

	assign wi = iqtng_pkg::xorshift_next(noise_q);
	assign wq = iqtng_pkg::xorshift_next(wi);

	assign addr_a = {1'b0, phase_acc_q[PHASE_BITS-3 -: TABLE_ADDR_BITS]};
	assign addr_b = QTR_N - addr_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= iqtng_pkg::PHASE_STEP_RESET;
			tone_gain_q  <= iqtng_pkg::TONE_GAIN_RESET;
			noise_gain_q <= iqtng_pkg::NOISE_GAIN_RESET;
			phase_acc_q  <= '0;
			noise_q      <= iqtng_pkg::SEED_DEFAULT;
		end else begin
			if (take_in) begin
				phase_acc_q <= phase_acc_q + PHASE_BITS'(phase_step_q);
				noise_q     <= wq;
			end
			if (cfg_we) begin
				unique case (iqtng_pkg::cfg_reg_t'(cfg_index))
					iqtng_pkg::REG_PHASE_STEP: phase_step_q <= cfg_data;
					iqtng_pkg::REG_NOISE_SEED: noise_q <= (cfg_data == '0) ?
						iqtng_pkg::SEED_DEFAULT : cfg_data;
					iqtng_pkg::REG_TONE_GAIN:  tone_gain_q  <= cfg_data[iqtng_pkg::GAIN_BITS-1:0];
					iqtng_pkg::REG_NOISE_GAIN: noise_gain_q <= cfg_data[iqtng_pkg::GAIN_BITS-1:0];
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ld1) begin
				v_s1 <= sample_valid;
			end
			if (ld2) begin
				v_s2 <= v_s1;
			end
			if (ld3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			wi_s1   <= wi;
			wq_s1   <= wq;
			quad_s1 <= iqtng_pkg::quad_t'(phase_acc_q[PHASE_BITS-1 -: 2]);
			last_s1 <= block_end;
		end
	end

	iqtng_sine_rom #(
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS),
		.SAMPLE_BITS     (SAMPLE_BITS)
	) u_rom (
		.clk    (clk),
		.rd_en  (ld1),
		.addr_a (addr_a),
		.addr_b (addr_b),
		.data_a (ta_s1),
		.data_b (tb_s1)
	);

	iqtng_mix #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mix (
		.clk        (clk),
		.en         (en),
		.ta_s1      (ta_s1),
		.tb_s1      (tb_s1),
		.quad_s1    (quad_s1),
		.wi_s1      (wi_s1),
		.wq_s1      (wq_s1),
		.last_s1    (last_s1),
		.tone_gain  (tone_gain_q),
		.noise_gain (noise_gain_q),
		.i_s3       (i_sample),
		.q_s3       (q_sample),
		.last_s3    (last)
	);

	a_noise_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |-> noise_q != '0)
		else $error("noise state reached zero");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (v_s1 && v_s2 && v_s3 && iq_stall))
		else $error("input stalled with an empty stage");

	a_take_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		take_in |=> v_s1)
		else $error("accepted transaction lost at stage 1");

	a_noise_step: assert property (@(posedge clk) disable iff (!arst_n)
		(take_in && !cfg_we) |=> noise_q ==
			iqtng_pkg::xorshift_next(iqtng_pkg::xorshift_next($past(noise_q))))
		else $error("noise state did not advance by two steps");

	a_phase_step: assert property (@(posedge clk) disable iff (!arst_n)
		(take_in && !cfg_we) |=> phase_acc_q ==
			PHASE_BITS'($past(phase_acc_q) + PHASE_BITS'($past(phase_step_q))))
		else $error("phase accumulator did not advance by the step");

endmodule

`default_nettype wire
